### sv/lsdrs_pkg.sv
// ----------------------------------------------------------------------------
// lsdrs_pkg - shared types and constants of the decimal radix sorter
// Field widths, the value ceiling, the per-cell control struct and the
// decimal digit counter used by the sorter top level.
// ----------------------------------------------------------------------------
package lsdrs_pkg;

  localparam int unsigned ValW   = 30;
  localparam int unsigned OpW    = 10;
  localparam int unsigned PassW  = 4;
  localparam logic [ValW-1:0] ValueCap = ValW'(999999999);

  typedef logic [ValW-1:0]  val_t;
  typedef logic [OpW-1:0]   op_t;
  typedef logic [PassW-1:0] pass_t;

  // Broadcast control for every cell of the row
  typedef struct packed {
    logic ins;    // place the broadcast value in order
    logic shift;  // move every entry one cell toward the head
  } cell_ctl_t;

  // Number of decimal digits of a value, one for zero
  function automatic pass_t digit_count(input val_t v);
    pass_t n;
    n = pass_t'(1);
    if (v >= ValW'(10))        n = pass_t'(2);
    if (v >= ValW'(100))       n = pass_t'(3);
    if (v >= ValW'(1000))      n = pass_t'(4);
    if (v >= ValW'(10000))     n = pass_t'(5);
    if (v >= ValW'(100000))    n = pass_t'(6);
    if (v >= ValW'(1000000))   n = pass_t'(7);
    if (v >= ValW'(10000000))  n = pass_t'(8);
    if (v >= ValW'(100000000)) n = pass_t'(9);
    return n;
  endfunction

endpackage

### sv/lsdrs_cell.sv
// ----------------------------------------------------------------------------
// lsdrs_cell - one entry of the sorting row
// Holds one value and its valid bit. Takes the broadcast value or its left
// neighbor's value on an ordered insert, and its right neighbor's on a shift.
// ----------------------------------------------------------------------------
module lsdrs_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lsdrs_pkg::cell_ctl_t ctl_i,
  input  lsdrs_pkg::val_t      ins_val_i,
  input  logic                 prev_lt_i,
  input  lsdrs_pkg::val_t      prev_val_i,
  input  logic                 prev_vld_i,
  input  lsdrs_pkg::val_t      next_val_i,
  input  logic                 next_vld_i,
  output logic                 lt_o,
  output lsdrs_pkg::val_t      val_o,
  output logic                 vld_o
);
  import lsdrs_pkg::*;

  val_t val_q, val_d;
  logic vld_q, vld_d;

  // New value goes in front of this entry (strictly less keeps order stable)
  assign lt_o = !vld_q || (ins_val_i < val_q);

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (ctl_i.shift) begin
      val_d = next_val_i;
      vld_d = next_vld_i;
    end else if (ctl_i.ins && lt_o) begin
      if (prev_lt_i) begin
        val_d = prev_val_i;
        vld_d = prev_vld_i;
      end else begin
        val_d = ins_val_i;
        vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign vld_o = vld_q;

endmodule

### sv/decimal_lsd_radix_sorter_unit.sv
// ----------------------------------------------------------------------------
// decimal_lsd_radix_sorter_unit - ascending sorter of a set of decimal values
// Collects a set of values and returns them ascending with the operation
// count of a base-10 least-significant-digit radix sort.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one value per request; tlast closes the set. Values above
//   999999999 are clamped. Requests beyond MAX_ITEMS are dropped, but their
//   tlast still closes the set.
//   Each accepted value is placed in order at once in a row of MAX_ITEMS
//   cells, so the set is sorted when the closing request is taken.
//   Output stream: starting the cycle after the closing request, one request
//   per stored value, ascending, each carrying op_count = items * passes,
//   where passes is the decimal digit count of the largest value (one for
//   all zeros). tlast marks the final value. The row shifts one cell toward
//   the head per output request, one value per cycle while tready is high.
//   The input side is held off (tready low) while a set is being emitted;
//   a stalled receiver simply holds the head value and the whole row.
//   Reset: clears all cell valid bits, the count and the pass tracker; the
//   block comes up ready to load.
// ----------------------------------------------------------------------------
module decimal_lsd_radix_sorter_unit #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [29:0] value, [31:30] zero
  input  logic        s_axis_tlast_i,   // last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [29:0] value_res, [39:30] op_count
  output logic        m_axis_tlast_o    // last_res
);
  import lsdrs_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ITEMS);

  localparam logic StLoad  = 1'b0;
  localparam logic StDrain = 1'b1;

  logic            state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  pass_t           pass_q, pass_d;
  op_t             op_q, op_d;

  val_t      in_val;
  val_t      sat_val;
  pass_t     in_pass;
  logic      in_acc, out_acc;
  logic      has_room;
  cell_ctl_t ctl;

  val_t cell_val [MAX_ITEMS];
  logic cell_vld [MAX_ITEMS];
  logic cell_lt  [MAX_ITEMS];

  // Clamp the incoming value and size its digit count
  assign in_val  = s_axis_tdata_i[ValW-1:0];
  assign sat_val = (in_val > ValueCap) ? ValueCap : in_val;
  assign in_pass = digit_count(sat_val);

  assign s_axis_tready_o = (state_q == StLoad);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc  = m_axis_tvalid_o && m_axis_tready_i;
  assign has_room = (cnt_q < MaxCnt);

  // Insert only while a free cell remains; advance the row on each output
  assign ctl.ins   = in_acc && has_room;
  assign ctl.shift = out_acc;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pass_d  = pass_q;
    op_d    = op_q;
    case (state_q)
      StLoad: begin
        if (ctl.ins) begin
          cnt_d  = cnt_q + CntW'(1);
          pass_d = (in_pass > pass_q) ? in_pass : pass_q;
        end
        if (in_acc && s_axis_tlast_i) begin
          state_d = StDrain;
          op_d    = OpW'(cnt_d) * OpW'(pass_d);
        end
      end
      StDrain: begin
        if (out_acc) begin
          cnt_d = cnt_q - CntW'(1);
          // Drop back to loading once the final value has gone out
          if (cnt_q == CntW'(1)) begin
            state_d = StLoad;
            pass_d  = pass_t'(1);
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      pass_q  <= pass_t'(1);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pass_q  <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  // Row of cells, kept sorted ascending from cell 0
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic prev_lt;
    val_t prev_val;
    logic prev_vld;
    val_t next_val;
    logic next_vld;

    if (i == 0) begin : g_head
      assign prev_lt  = 1'b0;
      assign prev_val = '0;
      assign prev_vld = 1'b0;
    end else begin : g_body
      assign prev_lt  = cell_lt[i-1];
      assign prev_val = cell_val[i-1];
      assign prev_vld = cell_vld[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_val = '0;
      assign next_vld = 1'b0;
    end else begin : g_mid
      assign next_val = cell_val[i+1];
      assign next_vld = cell_vld[i+1];
    end

    lsdrs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .ins_val_i  (sat_val),
      .prev_lt_i  (prev_lt),
      .prev_val_i (prev_val),
      .prev_vld_i (prev_vld),
      .next_val_i (next_val),
      .next_vld_i (next_vld),
      .lt_o       (cell_lt[i]),
      .val_o      (cell_val[i]),
      .vld_o      (cell_vld[i])
    );
  end

  // Head cell feeds the output directly from its register
  assign m_axis_tvalid_o = (state_q == StDrain);
  assign m_axis_tdata_o  = {op_q, cell_val[0]};
  assign m_axis_tlast_o  = (cnt_q == CntW'(1));

endmodule

### sv/lsdrs_checker.sv
// ----------------------------------------------------------------------------
// lsdrs_checker - port-level checks of the decimal radix sorter
// Watches both streams of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module lsdrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // No loading while a set is being emitted
  a_no_load_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input accepted during output burst");

  // Closing request starts the burst on the next cycle
  a_burst_follows_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |=> m_axis_tvalid_o)
    else $error("no output after closing request");

  // Values leave in ascending order within a burst
  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=>
      (m_axis_tvalid_o && (m_axis_tdata_o[29:0] >= $past(m_axis_tdata_o[29:0]))))
    else $error("output out of order");

  // Operation count is the same for every value of a burst
  a_op_count_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && $past(m_axis_tvalid_o)) |-> $stable(m_axis_tdata_o[39:30]))
    else $error("op_count changed within burst");

  // Stalled output holds its request
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("stalled output request changed");

endmodule

bind decimal_lsd_radix_sorter_unit lsdrs_checker u_lsdrs_checker (.*);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for the decimal LSD radix sorter
// Streams sets of decimal values into the sorter and checks every sorted
// result against an in-bench base-10 radix sort model kept by a scoreboard.
// Both stream sides idle and stall at random in the first two of three random phases; the third never idles.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsdrs_pkg::*;

  localparam int unsigned StoreDepth = 64;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 115;

  typedef struct {
    val_t value;
    op_t  ops;
    logic last;
  } sorted_rec_t;

  // Holds the set being loaded, sorts it when the set closes, and queues
  // the sorted results in emission order.
  class sort_scoreboard;
    val_t        held[$];
    val_t        largest;
    sorted_rec_t sorted_q[$];
    int unsigned errors;
    int unsigned sets_closed;
    int unsigned dropped;
    int unsigned clamped;
    int unsigned checked;

    function new();
      largest = '0;
      errors = 0;
      sets_closed = 0;
      dropped = 0;
      clamped = 0;
      checked = 0;
    endfunction

    function int unsigned decimal_digits(input val_t v);
      int unsigned n;
      int unsigned t;
      n = 1;
      t = v;
      while (t >= 10) begin
        t = t / 10;
        n++;
      end
      return n;
    endfunction

    // Stable LSD sort: gather by digit 0..9, one pass per digit position
    function void radix_sort_held(input int unsigned passes);
      val_t        scratch[$];
      int unsigned weight;
      weight = 1;
      for (int unsigned p = 0; p < passes; p++) begin
        scratch.delete();
        for (int unsigned d = 0; d < 10; d++) begin
          foreach (held[i]) begin
            if ((int'(held[i]) / weight) % 10 == d) scratch.push_back(held[i]);
          end
        end
        held = scratch;
        weight = weight * 10;
      end
    endfunction

    function void note_request(input val_t raw, input logic closing);
      val_t        v;
      int unsigned passes;
      int unsigned n;
      sorted_rec_t rec;
      v = raw;
      if (v > ValueCap) begin
        v = ValueCap;
        clamped++;
      end
      if (held.size() < StoreDepth) begin
        held.push_back(v);
        if (v > largest) largest = v;
      end else begin
        dropped++;
      end
      if (!closing) return;
      n = held.size();
      passes = decimal_digits(largest);
      radix_sort_held(passes);
      foreach (held[i]) begin
        rec.value = held[i];
        rec.ops   = op_t'(n * passes);
        rec.last  = (i + 1 == n);
        sorted_q.push_back(rec);
      end
      held.delete();
      largest = '0;
      sets_closed++;
    endfunction

    function void check_result(input val_t value, input op_t ops, input logic last);
      sorted_rec_t want;
      if (sorted_q.size() == 0) begin
        $error("unexpected result: value_res=%0d op_count=%0d last_res=%0b",
               value, ops, last);
        errors++;
        return;
      end
      want = sorted_q.pop_front();
      checked++;
      if (value !== want.value) begin
        $error("value_res mismatch: expected %0d, actual %0d", want.value, value);
        errors++;
      end
      if (ops !== want.ops) begin
        $error("op_count mismatch: expected %0d, actual %0d", want.ops, ops);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_res mismatch: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return sorted_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  int unsigned send_idle_pct = 9;
  int unsigned recv_idle_pct = 75;
  int unsigned sent_requests = 0;
  int unsigned cycle_count = 0;

  sort_scoreboard sorted_sb = new();

  decimal_lsd_radix_sorter_unit #(
    .MAX_ITEMS(StoreDepth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),   // [29:0] value, [31:30] zero
    .s_axis_tlast_i (s_axis_tlast),   // last
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),   // [29:0] value_res, [39:30] op_count
    .m_axis_tlast_o (m_axis_tlast)    // last_res
  );

  always #10 clk_i = ~clk_i;

  // Receiver backpressure, redrawn every cycle
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Sample both handshakes with pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      sorted_sb.note_request(s_axis_tdata[29:0], s_axis_tlast);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sorted_sb.check_result(m_axis_tdata[29:0], m_axis_tdata[39:30], m_axis_tlast);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sorted_sb.outstanding());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one request, idling first at random, and hold it until taken
  task automatic send_value(input val_t v, input logic closing);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, v};
    s_axis_tlast  <= closing;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_requests++;
  endtask

  task automatic send_set(input val_t vals[$]);
    foreach (vals[i]) send_value(vals[i], i == vals.size() - 1);
  endtask

  // Random set: one digit span per set, with clamped, zero and repeated values
  task automatic send_random_set(input int unsigned size);
    val_t        vals[$];
    int unsigned span;
    int unsigned ceiling;
    int unsigned pick;
    span = $urandom_range(1, 9);
    ceiling = 1;
    repeat (span) ceiling = ceiling * 10;
    for (int unsigned i = 0; i < size; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) vals.push_back(val_t'($urandom_range(1000000000, 32'h3FFF_FFFF)));
      else if (pick == 1) vals.push_back('0);
      else if (pick == 2 && i > 0) vals.push_back(vals[i-1]);
      else vals.push_back(val_t'($urandom_range(0, ceiling - 1)));
    end
    send_set(vals);
  endtask

  // Let the closing request reach the scoreboard before polling it
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sorted_sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic run_random_phase(input bit hold_midway);
    int unsigned start;
    bit          held_off;
    start = sent_requests;
    held_off = 1'b0;
    while (sent_requests - start < PhaseItems) begin
      // Now and then fill the store near its depth, at times overfilling it so the tail gets dropped
      if ($urandom_range(0, 11) == 0) send_random_set($urandom_range(62, 70));
      else send_random_set($urandom_range(1, 16));
      if (hold_midway && !held_off && sent_requests - start >= PhaseItems / 2) begin
        wait_drained();
        held_off = 1'b1;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: lone zero, extremes with duplicates, clamping, digit borders
    send_set('{30'd0});
    send_set('{30'd999999999, 30'd0, 30'd5, 30'd5});
    send_set('{30'h3FFF_FFFF, 30'd1000000000, 30'd7});
    send_set('{30'd3, 30'd1, 30'd2});
    send_set('{30'd10, 30'd9, 30'd100, 30'd99});
    send_set('{30'd999999999});
    wait_drained();

    run_random_phase(1'b0);

    send_idle_pct = 75;
    recv_idle_pct = 9;
    run_random_phase(1'b1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(1'b0);

    repeat (20) @(posedge clk_i);

    $display("%0d requests in %0d sets, %0d results checked", sent_requests,
             sorted_sb.sets_closed, sorted_sb.checked);
    $display("%0d values clamped, %0d requests dropped on a full store",
             sorted_sb.clamped, sorted_sb.dropped);
    if (sorted_sb.errors == 0 && sorted_sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      if (sorted_sb.outstanding() != 0) begin
        $error("%0d expected results never arrived", sorted_sb.outstanding());
      end
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
